// ===== rtl/pdpm_pkg.sv =====
`timescale 1ns / 1ps

package pdpm_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;

    localparam int TICK_WIDTH   = 16;
    localparam int DUTY_WIDTH   = 12;
    localparam int WEIGHT_WIDTH = 8;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ACTIVE_LEVEL  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TIMEOUT_TICKS = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FILTER_WEIGHT = 2'd2;

    localparam logic              RESET_ACTIVE_LEVEL  = 1'b1;
    localparam logic [15:0]       RESET_TIMEOUT_TICKS = 16'd3636;
    localparam logic [7:0]        RESET_FILTER_WEIGHT = 8'd200;

    localparam logic [1:0] OUTCOME_TIMEOUT   = 2'd0;
    localparam logic [1:0] OUTCOME_NO_PERIOD = 2'd1;
    localparam logic [1:0] OUTCOME_PERIOD    = 2'd2;

    localparam int DUTY_SCALE = 1000;
    localparam int DUTY_MAX   = 4095;
    localparam int NUM_WIDTH  = 27;

    typedef struct packed {
        logic [1:0]            outcome;
        logic [TICK_WIDTH-1:0] period_ticks;
        logic [TICK_WIDTH-1:0] width_ticks;
    } pdpm_event_t;

endpackage

// ===== rtl/pdpm_front.sv =====
`timescale 1ns / 1ps

module pdpm_front
    import pdpm_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic        command,
    input  logic        pin_level,
    input  logic        active_level,
    input  logic [15:0] timeout_ticks,
    output logic        ev_push,
    output pdpm_event_t ev_data
);

    localparam logic [2:0] PH_IDLE         = 3'd0;
    localparam logic [2:0] PH_PREV_FRESH   = 3'd1;
    localparam logic [2:0] PH_PREV_SEEN    = 3'd2;
    localparam logic [2:0] PH_START_NOEDGE = 3'd3;
    localparam logic [2:0] PH_START_EDGE   = 3'd4;
    localparam logic [2:0] PH_STOP_NOEDGE  = 3'd5;
    localparam logic [2:0] PH_STOP_EDGE    = 3'd6;
    localparam logic [2:0] PH_NEXT         = 3'd7;

    logic [2:0]             phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] cd_reg, cd_next;
    logic [COUNT_WIDTH-1:0] prior_reg, prior_next;
    logic [COUNT_WIDTH-1:0] pstart_reg, pstart_next;
    logic [COUNT_WIDTH-1:0] pend_reg, pend_next;
    logic [COUNT_WIDTH-1:0] cd_dec, cd_load;
    logic [COUNT_WIDTH-1:0] diff_w, diff_p;
    logic                   hit;
    logic                   active;

    assign cd_dec  = cd_reg - 1'b1;
    assign hit     = (cd_dec == '0);
    assign active  = (pin_level == active_level);
    assign cd_load = (COUNT_WIDTH'(timeout_ticks) == '0) ? COUNT_WIDTH'(1)
                                                         : COUNT_WIDTH'(timeout_ticks);

    always_comb begin
        phase_next  = phase_reg;
        cd_next     = cd_reg;
        prior_next  = prior_reg;
        pstart_next = pstart_reg;
        pend_next   = pend_reg;
        ev_push     = 1'b0;
        ev_data     = '0;
        diff_w      = '0;
        diff_p      = '0;
        if (accept) begin
            if (command) begin
                cd_next     = cd_load;
                prior_next  = '0;
                pstart_next = '0;
                pend_next   = '0;
                phase_next  = PH_PREV_FRESH;
            end else if (phase_reg != PH_IDLE) begin
                if (phase_next == PH_PREV_FRESH || phase_next == PH_PREV_SEEN) begin
                    if (active) begin
                        phase_next = PH_PREV_SEEN;
                        cd_next    = cd_dec;
                        if (hit) begin
                            ev_push    = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end else begin
                        prior_next = cd_reg;
                        phase_next = (phase_reg == PH_PREV_SEEN) ? PH_START_EDGE
                                                                 : PH_START_NOEDGE;
                    end
                end
                if (phase_next == PH_START_NOEDGE || phase_next == PH_START_EDGE) begin
                    if (!active) begin
                        cd_next = cd_dec;
                        if (hit) begin
                            ev_push    = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end else begin
                        pstart_next = cd_reg;
                        phase_next  = (phase_next == PH_START_EDGE) ? PH_STOP_EDGE
                                                                    : PH_STOP_NOEDGE;
                    end
                end
                if (phase_next == PH_STOP_NOEDGE || phase_next == PH_STOP_EDGE) begin
                    if (active) begin
                        cd_next = cd_dec;
                        if (hit) begin
                            ev_push    = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end else if (phase_next == PH_STOP_EDGE) begin
                        diff_w               = pstart_next - cd_reg;
                        diff_p               = prior_next - cd_reg;
                        ev_push              = 1'b1;
                        ev_data.width_ticks  = TICK_WIDTH'(diff_w);
                        ev_data.period_ticks = TICK_WIDTH'(diff_p);
                        ev_data.outcome      = OUTCOME_PERIOD;
                        phase_next           = PH_IDLE;
                    end else begin
                        pend_next  = cd_reg;
                        phase_next = PH_NEXT;
                    end
                end
                if (phase_next == PH_NEXT) begin
                    diff_w = pstart_next - pend_next;
                    if (!active) begin
                        cd_next = cd_dec;
                        if (hit) begin
                            ev_push             = 1'b1;
                            ev_data.width_ticks = TICK_WIDTH'(diff_w);
                            ev_data.outcome     = OUTCOME_NO_PERIOD;
                            phase_next          = PH_IDLE;
                        end
                    end else begin
                        diff_p               = pstart_next - cd_reg;
                        ev_push              = 1'b1;
                        ev_data.width_ticks  = TICK_WIDTH'(diff_w);
                        ev_data.period_ticks = TICK_WIDTH'(diff_p);
                        ev_data.outcome      = OUTCOME_PERIOD;
                        phase_next           = PH_IDLE;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            cd_reg     <= '0;
            prior_reg  <= '0;
            pstart_reg <= '0;
            pend_reg   <= '0;
        end else begin
            phase_reg  <= phase_next;
            cd_reg     <= cd_next;
            prior_reg  <= prior_next;
            pstart_reg <= pstart_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

// ===== rtl/pdpm_queue.sv =====
`timescale 1ns / 1ps

module pdpm_queue
    import pdpm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  pdpm_event_t push_data,
    input  logic        pop,
    output pdpm_event_t pop_data,
    output logic        full,
    output logic        not_empty
);

    localparam int DEPTH = 2;
    localparam int PTR_WIDTH = $clog2(DEPTH);

    pdpm_event_t              mem_reg [DEPTH];
    logic [PTR_WIDTH-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [PTR_WIDTH:0]       count_reg;

    assign full      = (count_reg == (PTR_WIDTH + 1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/pdpm_back.sv =====
`timescale 1ns / 1ps

module pdpm_back
    import pdpm_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    ev_valid,
    input  pdpm_event_t             ev_data,
    output logic                    ev_pop,
    input  logic [WEIGHT_WIDTH-1:0] filter_weight,
    output logic                    res_valid,
    input  logic                    res_ready,
    output logic [DUTY_WIDTH-1:0]   res_duty,
    output pdpm_event_t             res_event
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_FILT = 3'd2;
    localparam logic [2:0] S_PREP = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam int DIV_CNT_WIDTH = $clog2(NUM_WIDTH);
    localparam int PROD_WIDTH    = TICK_WIDTH + WEIGHT_WIDTH + 1;
    localparam int SUM_WIDTH     = PROD_WIDTH + 1;

    logic [2:0]                 state_reg, state_next;
    pdpm_event_t                ev_reg;
    logic [TICK_WIDTH-1:0]      filt_reg;
    logic [PROD_WIDTH-1:0]      prod_a_reg, prod_b_reg;
    logic [TICK_WIDTH-1:0]      rem_reg;
    logic [NUM_WIDTH-1:0]       quo_reg;
    logic [DIV_CNT_WIDTH-1:0]   cnt_reg;
    logic                       duty_ok_reg;
    logic                       out_valid_reg;
    logic [DUTY_WIDTH-1:0]      out_duty_reg;
    pdpm_event_t                out_event_reg;

    logic [WEIGHT_WIDTH:0]      keep_comp;
    logic [SUM_WIDTH-1:0]       filt_sum;
    logic                       period_used;
    logic                       duty_ok;
    logic [TICK_WIDTH:0]        rem_sh;
    logic                       ge;
    logic                       out_free;
    logic [DUTY_WIDTH-1:0]      duty_sat;

    assign keep_comp   = (WEIGHT_WIDTH + 1)'(256) - {1'b0, filter_weight};
    assign filt_sum    = SUM_WIDTH'(prod_a_reg) + SUM_WIDTH'(prod_b_reg) + SUM_WIDTH'(128);
    assign period_used = (ev_reg.outcome != OUTCOME_TIMEOUT) && (ev_reg.width_ticks != '0)
                         && (ev_reg.period_ticks != '0);
    assign duty_ok     = (ev_reg.outcome != OUTCOME_TIMEOUT) && (ev_reg.width_ticks != '0)
                         && (filt_reg != '0);
    assign rem_sh      = {rem_reg, quo_reg[NUM_WIDTH-1]};
    assign ge          = (rem_sh >= {1'b0, filt_reg});
    assign out_free    = !out_valid_reg || res_ready;
    assign duty_sat    = (quo_reg >= NUM_WIDTH'(DUTY_MAX)) ? DUTY_WIDTH'(DUTY_MAX)
                                                          : DUTY_WIDTH'(quo_reg) + 1'b1;
    assign ev_pop      = (state_reg == S_IDLE) && ev_valid;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (ev_valid) begin
                    state_next = S_MUL;
                end
            end
            S_MUL:  state_next = S_FILT;
            S_FILT: state_next = S_PREP;
            S_PREP: state_next = duty_ok ? S_DIV : S_DONE;
            S_DIV: begin
                if (cnt_reg == DIV_CNT_WIDTH'(NUM_WIDTH - 1)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            filt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_FILT && period_used) begin
                filt_reg <= (filt_reg == '0) ? ev_reg.period_ticks : filt_sum[8 +: TICK_WIDTH];
            end
            if (state_reg == S_DONE && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ev_pop) begin
            ev_reg <= ev_data;
        end
        if (state_reg == S_MUL) begin
            prod_a_reg <= PROD_WIDTH'(filt_reg) * PROD_WIDTH'(filter_weight);
            prod_b_reg <= PROD_WIDTH'(ev_reg.period_ticks) * PROD_WIDTH'(keep_comp);
        end
        if (state_reg == S_PREP) begin
            duty_ok_reg <= duty_ok;
            rem_reg     <= '0;
            cnt_reg     <= '0;
            quo_reg     <= NUM_WIDTH'(ev_reg.width_ticks) * NUM_WIDTH'(DUTY_SCALE)
                           + NUM_WIDTH'(filt_reg >> 2);
        end
        if (state_reg == S_DIV) begin
            rem_reg <= ge ? TICK_WIDTH'(rem_sh - {1'b0, filt_reg}) : rem_sh[TICK_WIDTH-1:0];
            quo_reg <= {quo_reg[NUM_WIDTH-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (state_reg == S_DONE && out_free) begin
            out_duty_reg  <= duty_ok_reg ? duty_sat : '0;
            out_event_reg <= ev_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_duty  = out_duty_reg;
    assign res_event = out_event_reg;

endmodule

// ===== rtl/pwm_duty_period_meter_top.sv =====
`timescale 1ns / 1ps

// PWM duty and period meter.
// The slave channel takes one item per transfer: s_tuser[0] is the command
// (1 starts a new measurement, 0 is a sample tick) and s_tdata[0] the sampled
// pin level. A sample tick is taken in every cycle while the front end has
// room to post a finished measurement; the phase tracking of a sample is done
// in the cycle of its transfer.
// A finished measurement passes through a two-entry queue to the back end,
// which updates the period filter and divides for the duty. It steps through
// a multiply state, a filter state, a prepare state and a 27-step restoring
// divider, and takes the next measurement only once its result is registered.
// A timeout, a zero width or an empty filter skips the divider.
// The master channel carries one result per transfer; a result waits in the
// output register while m_tready is low, the back end may finish the next one
// meanwhile, and the slave side stalls only when the queue is full.
// Reset clears all measurement state, the filter and m_tvalid, and loads register
// defaults; the user writes registers via cfg_we only while idle (not enforced).

module pwm_duty_period_meter_top
    import pdpm_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [0] pin_level, [7:1] zero
    input  logic [0:0]                 s_tuser,   // [0] command
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [47:0]                m_tdata,   // [11:0] duty_permille, [27:12] width_ticks,
                                                  // [43:28] period_ticks, [47:44] zero
    output logic [1:0]                 m_tuser,   // [1:0] outcome
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata
);

    logic                    active_level_reg;
    logic [15:0]             timeout_ticks_reg;
    logic [WEIGHT_WIDTH-1:0] filter_weight_reg;

    logic                    accept;
    logic                    ev_push;
    pdpm_event_t             ev_push_data;
    logic                    ev_pop;
    pdpm_event_t             ev_pop_data;
    logic                    q_full;
    logic                    q_not_empty;
    logic [DUTY_WIDTH-1:0]   res_duty;
    pdpm_event_t             res_event;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_level_reg  <= RESET_ACTIVE_LEVEL;
            timeout_ticks_reg <= RESET_TIMEOUT_TICKS;
            filter_weight_reg <= RESET_FILTER_WEIGHT;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ACTIVE_LEVEL:  active_level_reg  <= cfg_wdata[0];
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_wdata[15:0];
                CFG_FILTER_WEIGHT: filter_weight_reg <= cfg_wdata[WEIGHT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    pdpm_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .command      (s_tuser[0]),
        .pin_level    (s_tdata[0]),
        .active_level (active_level_reg),
        .timeout_ticks(timeout_ticks_reg),
        .ev_push      (ev_push),
        .ev_data      (ev_push_data)
    );

    pdpm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (ev_push),
        .push_data(ev_push_data),
        .pop      (ev_pop),
        .pop_data (ev_pop_data),
        .full     (q_full),
        .not_empty(q_not_empty)
    );

    pdpm_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ev_valid     (q_not_empty),
        .ev_data      (ev_pop_data),
        .ev_pop       (ev_pop),
        .filter_weight(filter_weight_reg),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res_duty     (res_duty),
        .res_event    (res_event)
    );

    assign m_tdata = {4'b0, res_event.period_ticks, res_event.width_ticks, res_duty};
    assign m_tuser = res_event.outcome;

endmodule
